>>> rtl/ooks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ooks_pkg
// Shared types and constants for the on-off keying sequencer: transaction
// payloads, configuration bundle and register map.
// ----------------------------------------------------------------------------
package ooks_pkg;

   // Register port geometry: 64-bit data, one register per 8 bytes
   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;
   localparam int IDX_W  = 3;

   // State and field widths
   localparam int DUR_W  = 32;
   localparam int ACC_W  = 33;
   localparam int POS_W  = 7;
   localparam int PAT_W  = 64;
   localparam int CNT_W  = 8;

   // Register indexes (byte address / 8)
   localparam logic [IDX_W-1:0] REG_MARK_LEN     = 3'd0;
   localparam logic [IDX_W-1:0] REG_SPACE_LEN    = 3'd1;
   localparam logic [IDX_W-1:0] REG_PAUSE_LEN    = 3'd2;
   localparam logic [IDX_W-1:0] REG_BIT_PATTERN  = 3'd3;
   localparam logic [IDX_W-1:0] REG_FRAME_BITS   = 3'd4;
   localparam logic [IDX_W-1:0] REG_REPEAT_COUNT = 3'd5;
   localparam logic [IDX_W-1:0] REG_LOOP_FOREVER = 3'd6;

   // Register reset values
   localparam logic [DUR_W-1:0] RST_MARK_LEN     = 32'd256;
   localparam logic [DUR_W-1:0] RST_SPACE_LEN    = 32'd256;
   localparam logic [DUR_W-1:0] RST_PAUSE_LEN    = 32'd0;
   localparam logic [PAT_W-1:0] RST_BIT_PATTERN  = 64'd0;
   localparam logic [POS_W-1:0] RST_FRAME_BITS   = 7'd0;
   localparam logic [CNT_W-1:0] RST_REPEAT_COUNT = 8'd1;
   localparam logic             RST_LOOP_FOREVER = 1'b0;

   // Largest frame count value (counter saturates here)
   localparam logic [CNT_W-1:0] FRAMES_MAX = 8'hFF;

   // Input transaction: one sample tick
   typedef struct packed {
      logic run;
      logic restart;
   } ooks_req_type;

   // Result transaction: one output sample
   typedef struct packed {
      logic key_on;
      logic done_res;
   } ooks_rsp_type;

   // Configuration bundle from the register file to the engine
   typedef struct packed {
      logic [DUR_W-1:0] mark_len;
      logic [DUR_W-1:0] space_len;
      logic [DUR_W-1:0] pause_len;
      logic [PAT_W-1:0] bit_pattern;
      logic [POS_W-1:0] frame_bits;
      logic [CNT_W-1:0] repeat_count;
      logic             loop_forever;
   } ooks_cfg_type;

endpackage

>>> rtl/ook_keying_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_keying_sequencer_core
// On-off keying mark/space sequencer: plays a frame of up to 64 bits as
// carrier gate samples, with fractional interval lengths, pauses and repeats.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction per sample tick (run, restart).
//  - rsp channel: one transaction per tick (key_on, done_res), in order.
//  - csr port: APB-style, 64-bit data, register i at byte address 8*i,
//    zero wait states. Write only while no tick is in flight.
//  - Path: an accepted tick is held in the input stage, moves to the result
//    register when that slot is free, and is offered on rsp from there.
//  - Throughput: one tick per cycle while rsp_ready stays high; the per-tick
//    work is a single pass of one 33-bit add, compare and subtract between the two registers.
//  - Stall: when rsp_ready is low the result register holds; the input
//    stage still takes one more tick, then req_ready drops.
//  - Reset: registers take their reset values, playback state clears and
//    both stages empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ook_keying_sequencer_core #(
   parameter int MAX_BITS  = 64,
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // tick input
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ooks_pkg::ooks_req_type      req_data,
   // sample output
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ooks_pkg::ooks_rsp_type      rsp_data,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ooks_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ooks_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ooks_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   ooks_pkg::ooks_cfg_type cfg;
   ooks_pkg::ooks_rsp_type tick_result;

   logic                   in_valid_ff,  in_valid_in;
   ooks_pkg::ooks_req_type in_data_ff,   in_data_in;
   logic                   out_valid_ff, out_valid_in;
   ooks_pkg::ooks_rsp_type out_data_ff,  out_data_in;
   logic                   advance;

   ooks_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ooks_engine #(
      .MAX_BITS  (MAX_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .tick_fire (advance),
      .tick      (in_data_ff),
      .cfg       (cfg),
      .result    (tick_result)
   );

   // Stage handshake: the staged tick moves on when the result slot frees
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input stage
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = tick_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Carrier is never keyed on a sample that reports done
   a_key_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.key_on && rsp_data.done_res))
      else $error("key_on asserted together with done");

   // A staged tick moves to an empty result register at once
   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("staged tick did not reach result register");

   // Input stage full and stalled downstream means no new tick taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("tick accepted while both stages stalled");

endmodule

>>> rtl/ooks_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ooks_csr
// APB-style register file. Seven registers at 8-byte spacing, zero wait
// states, read data returned combinationally from the selected register.
// ----------------------------------------------------------------------------
module ooks_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ooks_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ooks_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ooks_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output ooks_pkg::ooks_cfg_type      cfg
);

   logic [ooks_pkg::DUR_W-1:0] mark_len_ff,     mark_len_in;
   logic [ooks_pkg::DUR_W-1:0] space_len_ff,    space_len_in;
   logic [ooks_pkg::DUR_W-1:0] pause_len_ff,    pause_len_in;
   logic [ooks_pkg::PAT_W-1:0] bit_pattern_ff,  bit_pattern_in;
   logic [ooks_pkg::POS_W-1:0] frame_bits_ff,   frame_bits_in;
   logic [ooks_pkg::CNT_W-1:0] repeat_count_ff, repeat_count_in;
   logic                       loop_forever_ff, loop_forever_in;

   logic                       wr_en;
   logic [ooks_pkg::IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[ooks_pkg::ADDR_W-1:ooks_pkg::ADDR_W-ooks_pkg::IDX_W];

   // Write decode
   always_comb begin
      mark_len_in     = mark_len_ff;
      space_len_in    = space_len_ff;
      pause_len_in    = pause_len_ff;
      bit_pattern_in  = bit_pattern_ff;
      frame_bits_in   = frame_bits_ff;
      repeat_count_in = repeat_count_ff;
      loop_forever_in = loop_forever_ff;
      if (wr_en) begin
         case (reg_idx)
            ooks_pkg::REG_MARK_LEN:     mark_len_in     = csr_pwdata[ooks_pkg::DUR_W-1:0];
            ooks_pkg::REG_SPACE_LEN:    space_len_in    = csr_pwdata[ooks_pkg::DUR_W-1:0];
            ooks_pkg::REG_PAUSE_LEN:    pause_len_in    = csr_pwdata[ooks_pkg::DUR_W-1:0];
            ooks_pkg::REG_BIT_PATTERN:  bit_pattern_in  = csr_pwdata[ooks_pkg::PAT_W-1:0];
            ooks_pkg::REG_FRAME_BITS:   frame_bits_in   = csr_pwdata[ooks_pkg::POS_W-1:0];
            ooks_pkg::REG_REPEAT_COUNT: repeat_count_in = csr_pwdata[ooks_pkg::CNT_W-1:0];
            ooks_pkg::REG_LOOP_FOREVER: loop_forever_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_len_ff     <= ooks_pkg::RST_MARK_LEN;
         space_len_ff    <= ooks_pkg::RST_SPACE_LEN;
         pause_len_ff    <= ooks_pkg::RST_PAUSE_LEN;
         bit_pattern_ff  <= ooks_pkg::RST_BIT_PATTERN;
         frame_bits_ff   <= ooks_pkg::RST_FRAME_BITS;
         repeat_count_ff <= ooks_pkg::RST_REPEAT_COUNT;
         loop_forever_ff <= ooks_pkg::RST_LOOP_FOREVER;
      end else begin
         mark_len_ff     <= mark_len_in;
         space_len_ff    <= space_len_in;
         pause_len_ff    <= pause_len_in;
         bit_pattern_ff  <= bit_pattern_in;
         frame_bits_ff   <= frame_bits_in;
         repeat_count_ff <= repeat_count_in;
         loop_forever_ff <= loop_forever_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         ooks_pkg::REG_MARK_LEN:     csr_prdata = ooks_pkg::DATA_W'(mark_len_ff);
         ooks_pkg::REG_SPACE_LEN:    csr_prdata = ooks_pkg::DATA_W'(space_len_ff);
         ooks_pkg::REG_PAUSE_LEN:    csr_prdata = ooks_pkg::DATA_W'(pause_len_ff);
         ooks_pkg::REG_BIT_PATTERN:  csr_prdata = ooks_pkg::DATA_W'(bit_pattern_ff);
         ooks_pkg::REG_FRAME_BITS:   csr_prdata = ooks_pkg::DATA_W'(frame_bits_ff);
         ooks_pkg::REG_REPEAT_COUNT: csr_prdata = ooks_pkg::DATA_W'(repeat_count_ff);
         ooks_pkg::REG_LOOP_FOREVER: csr_prdata = ooks_pkg::DATA_W'(loop_forever_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   assign cfg.mark_len     = mark_len_ff;
   assign cfg.space_len    = space_len_ff;
   assign cfg.pause_len    = pause_len_ff;
   assign cfg.bit_pattern  = bit_pattern_ff;
   assign cfg.frame_bits   = frame_bits_ff;
   assign cfg.repeat_count = repeat_count_ff;
   assign cfg.loop_forever = loop_forever_ff;

endmodule

>>> rtl/ooks_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ooks_engine
// Playback state and per-tick logic. One tick is evaluated per cycle from
// the staged input transaction; state commits when the tick advances.
// ----------------------------------------------------------------------------
module ooks_engine #(
   parameter int MAX_BITS  = 64,
   parameter int FRAC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_fire,
   input  ooks_pkg::ooks_req_type tick,
   input  ooks_pkg::ooks_cfg_type cfg,
   output ooks_pkg::ooks_rsp_type result
);

   localparam int ACC_W = ooks_pkg::ACC_W;
   localparam int DUR_W = ooks_pkg::DUR_W;
   localparam int POS_W = ooks_pkg::POS_W;
   localparam int CNT_W = ooks_pkg::CNT_W;
   localparam int PIX_W = $clog2(ooks_pkg::PAT_W);

   // One sample in fixed point, and the clamp for the frame length
   localparam logic [ACC_W-1:0] ONE_SAMPLE = ACC_W'(1) << FRAC_BITS;
   localparam logic [DUR_W-1:0] ONE_DUR    = ONE_SAMPLE[DUR_W-1:0];
   localparam logic [POS_W-1:0] MAX_LEN    = POS_W'(MAX_BITS);

   logic [POS_W-1:0] bit_position_ff,  bit_position_in;
   logic [ACC_W-1:0] frac_acc_ff,      frac_acc_in;
   logic [DUR_W-1:0] interval_len_ff,  interval_len_in;
   logic [CNT_W-1:0] frames_sent_ff,   frames_sent_in;
   logic             pausing_ff,       pausing_in;
   logic             finished_ff,      finished_in;

   logic [POS_W-1:0] len;
   logic [DUR_W-1:0] mark_dur;
   logic [DUR_W-1:0] space_dur;
   logic [ACC_W-1:0] acc_sum;
   logic             key;
   logic             finish_now;

   // Mark and space durations below one sample act as one sample
   assign mark_dur  = (cfg.mark_len  < ONE_DUR) ? ONE_DUR : cfg.mark_len;
   assign space_dur = (cfg.space_len < ONE_DUR) ? ONE_DUR : cfg.space_len;
   assign len       = (cfg.frame_bits > MAX_LEN) ? MAX_LEN : cfg.frame_bits;

   // Per-tick next state
   always_comb begin
      // restart clears playback before the tick is handled
      if (tick.restart) begin
         bit_position_in = '0;
         frac_acc_in     = '0;
         interval_len_in = '0;
         frames_sent_in  = '0;
         pausing_in      = 1'b0;
         finished_in     = 1'b0;
      end else begin
         bit_position_in = bit_position_ff;
         frac_acc_in     = frac_acc_ff;
         interval_len_in = interval_len_ff;
         frames_sent_in  = frames_sent_ff;
         pausing_in      = pausing_ff;
         finished_in     = finished_ff;
      end
      key        = 1'b0;
      finish_now = 1'b0;
      acc_sum    = '0;

      if (tick.run && !finished_in && (len != '0)) begin
         // set up the next interval
         if (interval_len_in == '0) begin
            if (pausing_in) begin
               interval_len_in = cfg.pause_len;
            end else if (bit_position_in < len) begin
               interval_len_in = cfg.bit_pattern[bit_position_in[PIX_W-1:0]] ?
                                 mark_dur : space_dur;
            end else begin
               // end of frame
               if (frames_sent_in != ooks_pkg::FRAMES_MAX) begin
                  frames_sent_in = frames_sent_in + CNT_W'(1);
               end
               if (cfg.loop_forever || (frames_sent_in < cfg.repeat_count)) begin
                  bit_position_in = '0;
                  frac_acc_in     = '0;
                  if (cfg.pause_len != '0) begin
                     pausing_in      = 1'b1;
                     interval_len_in = cfg.pause_len;
                  end else begin
                     interval_len_in = cfg.bit_pattern[0] ? mark_dur : space_dur;
                  end
               end else begin
                  finished_in = 1'b1;
                  finish_now  = 1'b1;
               end
            end
         end

         if (!finish_now) begin
            key = !pausing_in && (bit_position_in < len) &&
                  cfg.bit_pattern[bit_position_in[PIX_W-1:0]];
            // advance one sample, carry the remainder into the next interval
            acc_sum = frac_acc_in + ONE_SAMPLE;
            if (acc_sum >= {1'b0, interval_len_in}) begin
               frac_acc_in     = acc_sum - {1'b0, interval_len_in};
               interval_len_in = '0;
               if (pausing_in) begin
                  pausing_in      = 1'b0;
                  bit_position_in = '0;
               end else begin
                  bit_position_in = bit_position_in + POS_W'(1);
               end
            end else begin
               frac_acc_in = acc_sum;
            end
         end
      end

      result.key_on   = key;
      result.done_res = finished_in;
   end

   // State commit
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_position_ff <= '0;
         frac_acc_ff     <= '0;
         interval_len_ff <= '0;
         frames_sent_ff  <= '0;
         pausing_ff      <= 1'b0;
         finished_ff     <= 1'b0;
      end else if (tick_fire) begin
         bit_position_ff <= bit_position_in;
         frac_acc_ff     <= frac_acc_in;
         interval_len_ff <= interval_len_in;
         frames_sent_ff  <= frames_sent_in;
         pausing_ff      <= pausing_in;
         finished_ff     <= finished_in;
      end
   end

   // Finished stays set until a restart
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff && !(tick_fire && tick.restart) |=> finished_ff)
      else $error("finished flag dropped without restart");

   // Frame count only grows between restarts
   a_frames_monotonic: assert property (@(posedge clock) disable iff (reset)
      tick_fire && !tick.restart |=> frames_sent_ff >= $past(frames_sent_ff))
      else $error("frame count decreased without restart");

   // A pause always sits at the start of a frame
   a_pause_at_start: assert property (@(posedge clock) disable iff (reset)
      pausing_ff |-> bit_position_ff == '0)
      else $error("pausing with nonzero bit position");

endmodule
